FILE: rtl/core/dhtr_pkg.sv
package dhtr_pkg;

   localparam int FRAME_BITS  = 40;
   localparam int BIT_COUNT_W = 6;
   localparam int TICK_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_TIMEOUT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_HIGH      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_HIGH  = 3'd4;

   localparam logic [7:0]  ONE_THRESHOLD_RESET = 8'd40;
   localparam logic [15:0] LEVEL_TIMEOUT_RESET = 16'd2000;
   localparam logic [15:0] START_LOW_RESET     = 16'd20000;
   localparam logic [15:0] PRE_HIGH_RESET      = 16'd1000;
   localparam logic [7:0]  RELEASE_HIGH_RESET  = 8'd30;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_PRE       = 4'd1,
      PH_LOW       = 4'd2,
      PH_REL       = 4'd3,
      PH_ACK_LOW   = 4'd4,
      PH_ACK_HIGH  = 4'd5,
      PH_DATA_LOW  = 4'd6,
      PH_BIT_HIGH  = 4'd7,
      PH_BIT_MEAS  = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TIMEOUT  = 2'd1,
      ST_CHECKSUM = 2'd2
   } status_type;

   typedef struct packed {
      logic start_request;
      logic line_level;
   } req_word_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      status_type        status;
      logic [11:0]       humidity_tenths;
      logic signed [11:0] temperature_tenths;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  one_threshold_us;
      logic [15:0] level_timeout_us;
      logic [15:0] start_low_us;
      logic [15:0] pre_high_us;
      logic [7:0]  release_high_us;
   } cfg_type;

   function automatic logic [11:0] times_ten(input logic [7:0] b);
      return {1'b0, b, 3'b000} + {3'b000, b, 1'b0};
   endfunction

endpackage

FILE: rtl/core/dhtr_csr.sv
module dhtr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [dhtr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dhtr_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output dhtr_pkg::cfg_type                   cfg
);

   dhtr_pkg::cfg_type cfg_ff;
   dhtr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            dhtr_pkg::CSR_ONE_THRESHOLD: cfg_in.one_threshold_us = csr_write_data[7:0];
            dhtr_pkg::CSR_LEVEL_TIMEOUT: cfg_in.level_timeout_us = csr_write_data;
            dhtr_pkg::CSR_START_LOW:     cfg_in.start_low_us     = csr_write_data;
            dhtr_pkg::CSR_PRE_HIGH:      cfg_in.pre_high_us      = csr_write_data;
            dhtr_pkg::CSR_RELEASE_HIGH:  cfg_in.release_high_us  = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_threshold_us <= dhtr_pkg::ONE_THRESHOLD_RESET;
         cfg_ff.level_timeout_us <= dhtr_pkg::LEVEL_TIMEOUT_RESET;
         cfg_ff.start_low_us     <= dhtr_pkg::START_LOW_RESET;
         cfg_ff.pre_high_us      <= dhtr_pkg::PRE_HIGH_RESET;
         cfg_ff.release_high_us  <= dhtr_pkg::RELEASE_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/dhtr_core.sv
module dhtr_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  dhtr_pkg::req_word_type req_word,
   input  dhtr_pkg::cfg_type      cfg,
   output dhtr_pkg::rsp_word_type rsp_word
);

   localparam int FB = dhtr_pkg::FRAME_BITS;
   localparam int BW = dhtr_pkg::BIT_COUNT_W;
   localparam int TW = dhtr_pkg::TICK_W;

   dhtr_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0]       tick_ff, tick_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [FB-1:0]       frame_ff, frame_in;

   // frame decode, taken from the frame as it stands after the newest bit
   logic [FB-1:0] frame_shift;
   logic [7:0]    b0, b1, b2, b3, b4, csum;
   logic [11:0]   hum, mag;
   logic          bit_val;

   always_comb begin : next_state_comb
      dhtr_pkg::phase_type ph;
      logic [TW-1:0]       tc;
      logic [BW-1:0]       bc;
      logic [FB-1:0]       fr;
      logic                wrong;
      logic [BW-1:0]       bc_next;

      ph    = phase_ff;
      tc    = tick_ff;
      bc    = bit_ff;
      fr    = frame_ff;
      wrong = 1'b0;
      rsp_word = '0;

      if (ph == dhtr_pkg::PH_IDLE && req_word.start_request) begin
         ph = dhtr_pkg::PH_PRE;
         tc = '0;
         bc = '0;
         fr = '0;
      end

      // zero-length drive phases fall straight through
      if (ph == dhtr_pkg::PH_PRE && tc >= cfg.pre_high_us) begin
         ph = dhtr_pkg::PH_LOW;
         tc = '0;
      end
      if (ph == dhtr_pkg::PH_LOW && tc >= cfg.start_low_us) begin
         ph = dhtr_pkg::PH_REL;
         tc = '0;
      end
      if (ph == dhtr_pkg::PH_REL && tc >= TW'(cfg.release_high_us)) begin
         ph = dhtr_pkg::PH_ACK_LOW;
         tc = '0;
      end

      bc_next     = bc + BW'(1);

      phase_in = ph;
      tick_in  = tc;
      bit_in   = bc;
      frame_in = fr;

      unique case (ph) inside
         dhtr_pkg::PH_IDLE: ;
         dhtr_pkg::PH_PRE, dhtr_pkg::PH_LOW, dhtr_pkg::PH_REL: begin
            tick_in = tc + TW'(1);
            rsp_word.drive_low = (ph == dhtr_pkg::PH_LOW);
            rsp_word.busy_res  = 1'b1;
         end
         dhtr_pkg::PH_ACK_LOW, dhtr_pkg::PH_DATA_LOW: begin
            if (req_word.line_level) begin
               wrong = 1'b1;
            end else begin
               phase_in = (ph == dhtr_pkg::PH_ACK_LOW) ? dhtr_pkg::PH_ACK_HIGH
                                                      : dhtr_pkg::PH_BIT_HIGH;
               tick_in = '0;
               rsp_word.busy_res = 1'b1;
            end
         end
         dhtr_pkg::PH_ACK_HIGH, dhtr_pkg::PH_BIT_HIGH: begin
            if (!req_word.line_level) begin
               wrong = 1'b1;
            end else begin
               phase_in = (ph == dhtr_pkg::PH_ACK_HIGH) ? dhtr_pkg::PH_DATA_LOW
                                                       : dhtr_pkg::PH_BIT_MEAS;
               tick_in = '0;
               rsp_word.busy_res = 1'b1;
            end
         end
         dhtr_pkg::PH_BIT_MEAS: begin
            if (req_word.line_level) begin
               wrong = 1'b1;
            end else begin
               frame_in = frame_shift;
               bit_in   = bc_next;
               tick_in  = '0;
               if (bc_next >= BW'(FB)) begin
                  phase_in = dhtr_pkg::PH_IDLE;
                  rsp_word.done_res = 1'b1;
                  if (csum != b4) begin
                     rsp_word.status = dhtr_pkg::ST_CHECKSUM;
                  end else begin
                     rsp_word.status             = dhtr_pkg::ST_OK;
                     rsp_word.humidity_tenths    = hum;
                     rsp_word.temperature_tenths = b2[7] ? $signed(12'd0 - mag)
                                                         : $signed(mag);
                  end
               end else begin
                  phase_in = dhtr_pkg::PH_BIT_HIGH;
                  rsp_word.busy_res = 1'b1;
               end
            end
         end
         default: begin
            phase_in = dhtr_pkg::PH_IDLE;
            tick_in  = '0;
         end
      endcase

      if (wrong) begin
         if (tc >= cfg.level_timeout_us) begin
            phase_in = dhtr_pkg::PH_IDLE;
            tick_in  = '0;
            rsp_word.done_res = 1'b1;
            rsp_word.status   = dhtr_pkg::ST_TIMEOUT;
         end else begin
            tick_in = tc + TW'(1);
            rsp_word.busy_res = 1'b1;
         end
      end
   end

   // only used in the measure phase, where the tick count is the registered one
   assign bit_val     = (tick_ff >= TW'(cfg.one_threshold_us));
   assign frame_shift = {frame_ff[FB-2:0], bit_val};

   assign b0   = frame_shift[39:32];
   assign b1   = frame_shift[31:24];
   assign b2   = frame_shift[23:16];
   assign b3   = frame_shift[15:8];
   assign b4   = frame_shift[7:0];
   assign csum = b0 + b1 + b2 + b3;
   assign hum  = dhtr_pkg::times_ten(b0) + {4'b0000, b1};
   assign mag  = dhtr_pkg::times_ten({1'b0, b2[6:0]}) + {4'b0000, b3};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dhtr_pkg::PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         frame_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         frame_ff <= frame_in;
      end
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_word.done_res |=> phase_ff == dhtr_pkg::PH_IDLE)
      else $error("read finished but phase did not return to idle");

   a_error_no_payload: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_word.status != dhtr_pkg::ST_OK |->
         rsp_word.humidity_tenths == 12'd0 && rsp_word.temperature_tenths == 12'sd0)
      else $error("error status carries a nonzero reading");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != dhtr_pkg::PH_IDLE |-> bit_ff < BW'(FB))
      else $error("bit count ran past the frame while busy");

endmodule

FILE: rtl/core/dhtr_out_buf.sv
module dhtr_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dhtr_pkg::rsp_word_type push_word,
   output logic                   push_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dhtr_pkg::rsp_word_type rsp_word
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   dhtr_pkg::rsp_word_type main_ff, main_in;
   dhtr_pkg::rsp_word_type skid_ff, skid_in;
   logic                   pop;

   assign pop = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in = push_word;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign push_ready = !skid_valid_ff;
   assign rsp_valid  = main_valid_ff;
   assign rsp_word   = main_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid word held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("word pushed into full output buffer");

endmodule

FILE: rtl/core/dht11_single_wire_reader.sv
// Single-wire humidity/temperature sensor reader. Each request word is one
// microsecond tick: start_request and the sampled line level. Every accepted
// word yields exactly one response word (drive_low, busy, done, status and,
// on a good frame, humidity and signed temperature in tenths); it passes
// through the input register, then through the state update into the output
// buffer. One word is taken every clock; the only limit is the two-word output
// buffer, so req_stall rises once two response words wait under rsp_stall and
// a third sits in the input register. CSR writes are expected only while no
// word is in flight.
module dht11_single_wire_reader (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dhtr_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dhtr_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_write_en,
   input  logic [dhtr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dhtr_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   dhtr_pkg::cfg_type      cfg;
   dhtr_pkg::req_word_type in_word_ff;
   logic                   in_valid_ff, in_valid_in;
   logic                   buf_ready;
   logic                   fire;
   logic                   req_take;
   dhtr_pkg::rsp_word_type core_word;

   assign fire      = in_valid_ff && buf_ready;
   assign req_stall = in_valid_ff && !buf_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_word_ff <= req_word;
      end
   end

   dhtr_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   dhtr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_word (in_word_ff),
      .cfg      (cfg),
      .rsp_word (core_word)
   );

   dhtr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .push_word  (core_word),
      .push_ready (buf_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule
